[hw/rtl/triangle_strip_to_list_unit_macros.svh]
// Assertion macros for the triangle strip to triangle list unit.
// Included by the top level; the checks compile away under SYNTHESIS.
`ifndef TRIANGLE_STRIP_TO_LIST_UNIT_MACROS_SVH
`define TRIANGLE_STRIP_TO_LIST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TSL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tsl assertion failed");
`define TSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tsl assertion failed");
`else
`define TSL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/tsl_pkg.sv]
// Package for the triangle strip to triangle list unit.
// Beat types, configuration write type, register indexes and status codes.
package tsl_pkg;

    localparam int unsigned IndexW     = 16;
    localparam int unsigned FirstW     = 15;
    localparam int unsigned StatusW    = 2;
    localparam int unsigned CfgIndexW  = 2;
    localparam int unsigned CfgDataW   = 15;

    localparam logic [IndexW-1:0] MaxStripLength = 16'd32767;
    localparam logic [IndexW:0]   ImplicitLimit  = 17'd32766;
    localparam logic [IndexW-1:0] MinTriVerts    = 16'd3;

    localparam logic [CfgIndexW-1:0] CfgImplicitMode = 2'd0;
    localparam logic [CfgIndexW-1:0] CfgFirstIndex   = 2'd1;
    localparam logic [CfgIndexW-1:0] CfgWindingFlip  = 2'd2;

    localparam logic [StatusW-1:0] StTriangle = 2'd0;
    localparam logic [StatusW-1:0] StShort    = 2'd1;
    localparam logic [StatusW-1:0] StLong     = 2'd2;
    localparam logic [StatusW-1:0] StOverflow = 2'd3;

    typedef struct packed {
        logic [IndexW-1:0] index_value;
        logic              last_of_strip;
    } t_in_beat;

    typedef struct packed {
        logic [IndexW-1:0]  tri_first;
        logic [IndexW-1:0]  tri_second;
        logic [IndexW-1:0]  tri_third;
        logic [StatusW-1:0] status;
        logic               strip_end;
    } t_out_beat;

    typedef struct packed {
        logic                 we;
        logic [CfgIndexW-1:0] index;
        logic [CfgDataW-1:0]  data;
    } t_cfg_wr;

endpackage

[hw/rtl/tsl_core.sv]
// Strip state, configuration registers and per-vertex triangle assembly.
// Depends on tsl_pkg.
module tsl_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsl_pkg::t_cfg_wr    i_cfg,
    input  logic                i_accept,
    input  tsl_pkg::t_in_beat   i_in,
    output logic                o_push,
    output tsl_pkg::t_out_beat  o_res
);

    logic                          r_implicit;
    logic [tsl_pkg::FirstW-1:0]    r_first_index;
    logic                          r_winding_flip;
    logic [tsl_pkg::IndexW-1:0]    r_older;
    logic [tsl_pkg::IndexW-1:0]    r_newer;
    logic [tsl_pkg::IndexW-1:0]    r_position;
    logic [tsl_pkg::IndexW-1:0]    r_gen_count;
    logic                          r_faulted;

    logic [tsl_pkg::IndexW-1:0]    n_older;
    logic [tsl_pkg::IndexW-1:0]    n_newer;
    logic [tsl_pkg::IndexW-1:0]    n_position;
    logic [tsl_pkg::IndexW-1:0]    n_gen_count;
    logic                          n_faulted;

    logic [tsl_pkg::IndexW:0]      w_gen_sum;
    logic                          w_ovf;
    logic [tsl_pkg::IndexW-1:0]    w_vertex;
    logic [tsl_pkg::IndexW-1:0]    w_n;
    logic                          w_swap;

    assign w_gen_sum = {2'b00, r_first_index} + {1'b0, r_gen_count};
    assign w_ovf     = r_implicit && (w_gen_sum > tsl_pkg::ImplicitLimit);
    assign w_vertex  = r_implicit ? w_gen_sum[tsl_pkg::IndexW-1:0] : i_in.index_value;
    assign w_n       = (r_position != '1) ? r_position + 1'b1 : r_position;
    assign w_swap    = r_winding_flip && !w_n[0];

    always_comb begin
        o_push       = 1'b0;
        o_res        = '0;
        o_res.strip_end = i_in.last_of_strip;
        n_faulted    = r_faulted;
        if (!r_faulted) begin
            if (w_ovf) begin
                o_push       = i_accept;
                o_res.status = tsl_pkg::StOverflow;
                n_faulted    = 1'b1;
            end else if (w_n > tsl_pkg::MaxStripLength) begin
                o_push       = i_accept;
                o_res.status = tsl_pkg::StLong;
                n_faulted    = 1'b1;
            end else if (w_n >= tsl_pkg::MinTriVerts) begin
                o_push           = i_accept;
                o_res.status     = tsl_pkg::StTriangle;
                o_res.tri_first  = w_swap ? r_newer : r_older;
                o_res.tri_second = w_swap ? r_older : r_newer;
                o_res.tri_third  = w_vertex;
            end else if (i_in.last_of_strip) begin
                o_push       = i_accept;
                o_res.status = tsl_pkg::StShort;
            end
        end

        if (i_in.last_of_strip) begin
            n_older    = '0;
            n_newer    = '0;
            n_position = '0;
            n_faulted  = 1'b0;
        end else begin
            n_older    = r_newer;
            n_newer    = w_vertex;
            n_position = w_n;
        end

        n_gen_count = r_gen_count;
        if (r_implicit && (r_gen_count != '1)) begin
            n_gen_count = r_gen_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_implicit     <= 1'b0;
            r_first_index  <= '0;
            r_winding_flip <= 1'b0;
            r_older        <= '0;
            r_newer        <= '0;
            r_position     <= '0;
            r_gen_count    <= '0;
            r_faulted      <= 1'b0;
        end else begin
            if (i_accept) begin
                r_older     <= n_older;
                r_newer     <= n_newer;
                r_position  <= n_position;
                r_gen_count <= n_gen_count;
                r_faulted   <= n_faulted;
            end
            if (i_cfg.we) begin
                case (i_cfg.index)
                    tsl_pkg::CfgImplicitMode: begin
                        r_implicit  <= i_cfg.data[0];
                        r_gen_count <= '0;
                    end
                    tsl_pkg::CfgFirstIndex: begin
                        r_first_index <= i_cfg.data[tsl_pkg::FirstW-1:0];
                        r_gen_count   <= '0;
                    end
                    tsl_pkg::CfgWindingFlip: begin
                        r_winding_flip <= i_cfg.data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[hw/rtl/tsl_out_queue.sv]
// Two-entry result queue that decouples the output stall from the input side.
// Depends on tsl_pkg.
module tsl_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tsl_pkg::t_out_beat  i_data,
    output logic                o_full,
    output logic                o_valid,
    output tsl_pkg::t_out_beat  o_data,
    input  logic                i_stall
);

    tsl_pkg::t_out_beat r_mem [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic [1:0]         n_count;
    logic               w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && !i_stall;

    always_comb begin
        case ({i_push, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

[hw/rtl/triangle_strip_to_list_unit.sv]
// Top level of the triangle strip to triangle list unit.
// Depends on tsl_pkg, tsl_core, tsl_out_queue and the assertion macro header.
//
// Each input beat carries one vertex index and a flag that closes its strip.
// From the third vertex of a strip on, every vertex yields one triangle beat;
// faults (short strip, long strip, implicit index overflow) yield a beat with
// a status code and zero indices. Some vertices yield no beat at all.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data; the
// user must write it only while the unit is idle, which the unit does not enforce.
// A write to implicit_mode or first_index restarts the implicit index counter.
// A result beat is assembled combinationally and registered in the result queue.
// Throughput is one vertex per cycle while o_in_stall is low, set by the single
// pass of combinational assembly between the strip registers and the result queue.
// Reset clears the strip state, the counter and all configuration registers.
// A stalled receiver fills a two-entry result queue; o_in_stall rises only
// when both entries are held, and falls the cycle after one is taken.
`include "triangle_strip_to_list_unit_macros.svh"
module triangle_strip_to_list_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tsl_pkg::CfgIndexW-1:0]     i_cfg_index,
    input  logic [tsl_pkg::CfgDataW-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    input  tsl_pkg::t_in_beat                 i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output tsl_pkg::t_out_beat                o_out_data,
    input  logic                              i_out_stall
);

    tsl_pkg::t_cfg_wr   w_cfg;
    tsl_pkg::t_out_beat w_res;
    logic               w_accept;
    logic               w_push;
    logic               w_full;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;
    assign w_accept    = i_in_valid && !w_full;
    assign o_in_stall  = w_full;

    tsl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_accept (w_accept),
        .i_in     (i_in_data),
        .o_push   (w_push),
        .o_res    (w_res)
    );

    tsl_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    `TSL_ASSERT_IMPL(a_stall_needs_results, i_clk, i_rst_n, o_in_stall, o_out_valid)
    `TSL_ASSERT_IMPL(a_fault_zero_indices, i_clk, i_rst_n, o_out_valid && (o_out_data.status != tsl_pkg::StTriangle), (o_out_data.tri_first == '0) && (o_out_data.tri_second == '0) && (o_out_data.tri_third == '0))
    `TSL_ASSERT_IMPL(a_short_at_end, i_clk, i_rst_n, o_out_valid && (o_out_data.status == tsl_pkg::StShort), o_out_data.strip_end)
    `TSL_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, w_push, o_out_valid)

endmodule
